[rtl/evad_pkg.sv]
// Shared types and constants of the energy voice activity detector.
package evad_pkg;

    // Width of the saturating square accumulator and its ceiling
    localparam int SUM_W = 40;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Width of one squared sample: the largest square is 2^30
    localparam int SQ_W = 31;

    // The mean square never exceeds 2^30, so its low bits carry it
    localparam int MEAN_W = 32;

    // Root and partial remainder widths of the digit-by-digit square root
    localparam int ROOT_W = 16;
    localparam int REM_W  = ROOT_W + 2;

    // Iteration counts of the serial divider and the square root
    localparam int ITER_W     = 6;
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;

    // Session counters and the configuration register widths
    localparam int CNT10_W = 10;
    localparam logic [CNT10_W-1:0] CNT10_MAX = {CNT10_W{1'b1}};
    localparam int THR_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENERGY_THRESHOLD = 2'd0,
        CFG_SILENCE_LIMIT    = 2'd1,
        CFG_MIN_SPEECH       = 2'd2
    } cfg_idx_t;

    // Register values after reset
    localparam logic [THR_W-1:0]   THR_RESET   = 16'd400;
    localparam logic [CNT10_W-1:0] LIMIT_RESET = 10'd35;
    localparam logic [CNT10_W-1:0] MIN_RESET   = 10'd5;

    // Stream payload widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_ROOT,
        ST_DECIDE
    } evad_state_t;

endpackage

[rtl/evad_sub_unit.sv]
// Shared subtract and compare unit used by the divider, the root and the threshold test.
module evad_sub_unit import evad_pkg::*; #(
    parameter int SUB_W = 20
) (
    input  logic [SUB_W-1:0] op_a,
    input  logic [SUB_W-1:0] op_b,
    output logic [SUB_W-1:0] diff,
    output logic             a_ge_b
);

    logic [SUB_W:0] wide_diff;

    // Subtract with one extra bit; a clear borrow means op_a >= op_b
    assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
    assign diff      = wide_diff[SUB_W-1:0];
    assign a_ge_b    = ~wide_diff[SUB_W];

endmodule

[rtl/energy_vad_end_of_speech_unit.sv]
// Top level of the energy voice activity detector with end-of-speech latch.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | tdata sample, tlast chunk_last, tuser new_session
//  m_      | out       | m_tvalid/m_tready  | tdata energy/speech/silence, tuser flags
//  cfg_    | in        | cfg_wen            | cfg_index, cfg_wdata
//
// A sample that does not close a chunk passes through accept, square and accumulate.
// A closing sample then runs the divider (one quotient bit a cycle), the square root (one
// root bit a cycle) and the threshold compare, all through the one shared subtractor.
// The result sits in an output register, so the next sample is taken while it waits;
// a new result waits in the compare step until that register is free.
// aresetn is synchronous: it clears the sequencer, the session state, the output
// valid and loads the reset register values.
module energy_vad_end_of_speech_unit import evad_pkg::*; #(
    parameter int MAX_CHUNK_SAMPLES = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample [15:0]
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tlast,
    // new_session [0]
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // energy [15:0], speech_seen [25:16], silence_seen [35:26], zero [39:36]
    output logic [M_DATA_W-1:0]   m_tdata,
    // is_speech [0], end_of_speech [1]
    output logic [M_USER_W-1:0]   m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
    localparam int SUB_W = (CNT_W + 1 > REM_W + 2) ? CNT_W + 1 : REM_W + 2;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHUNK_SAMPLES);

    evad_state_t state_reg, state_next;

    // Configuration registers
    logic [THR_W-1:0]   thr_reg;
    logic [CNT10_W-1:0] limit_reg;
    logic [CNT10_W-1:0] min_reg;

    // Session and chunk state
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT10_W-1:0] speech_reg, speech_next;
    logic [CNT10_W-1:0] silence_reg, silence_next;
    logic               ended_reg, ended_next;

    // Per-item working registers
    logic signed [S_DATA_W-1:0] sample_reg;
    logic                       last_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [SUM_W-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]           div_reg, div_next;
    logic [CNT_W-1:0]           rmd_reg, rmd_next;
    logic [MEAN_W-1:0]          rad_reg, rad_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [ROOT_W-1:0]          root_reg, root_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;

    // Output register
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [M_USER_W-1:0] m_user_reg, m_user_next;
    logic                m_valid_reg, m_valid_next;

    logic signed [2*S_DATA_W-1:0] product;
    logic [SUM_W:0]               sum_wide;
    logic [SUM_W-1:0]             sum_sat;
    logic [CNT_W:0]               div_shift;
    logic [REM_W+1:0]             root_shift;
    logic [REM_W-1:0]             root_trial;
    logic [SUB_W-1:0]             sub_a, sub_b, sub_diff;
    logic                         sub_ge;
    logic [CNT10_W-1:0]           silence_inc;
    logic                         accept_in;
    logic                         slot_free;

    assign accept_in = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign m_tvalid  = m_valid_reg;

    // Square the held sample; one 16x16 multiply, registered
    assign product = sample_reg * sample_reg;

    // Saturating accumulate of the square
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    // Operand shapes for the divider and the root step
    assign div_shift  = {rmd_reg, quo_reg[SUM_W-1]};
    assign root_shift = {rem_reg, rad_reg[MEAN_W-1 -: 2]};
    assign root_trial = {root_reg, 2'b01};

    // Route the shared unit by sequencer state
    always_comb begin
        case (state_reg)
            ST_DIVIDE: begin
                sub_a = SUB_W'(div_shift);
                sub_b = SUB_W'(div_reg);
            end
            ST_ROOT: begin
                sub_a = SUB_W'(root_shift);
                sub_b = SUB_W'(root_trial);
            end
            ST_DECIDE: begin
                sub_a = SUB_W'(root_reg);
                sub_b = SUB_W'(thr_reg);
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    evad_sub_unit #(
        .SUB_W (SUB_W)
    ) u_sub (
        .op_a   (sub_a),
        .op_b   (sub_b),
        .diff   (sub_diff),
        .a_ge_b (sub_ge)
    );

    assign silence_inc = (silence_reg == CNT10_MAX) ? silence_reg : silence_reg + 1'b1;

    // Sequencer: next state and working register updates
    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        speech_next  = speech_reg;
        silence_next = silence_reg;
        ended_next   = ended_reg;
        quo_next     = quo_reg;
        div_next     = div_reg;
        rmd_next     = rmd_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        iter_next    = iter_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                // Take a sample; a new session drops counters and the partial chunk
                if (accept_in) begin
                    if (s_tuser) begin
                        sum_next     = '0;
                        count_next   = '0;
                        speech_next  = '0;
                        silence_next = '0;
                        ended_next   = 1'b0;
                    end
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                // Accumulate until the chunk is full, then ignore samples
                if (count_reg < CNT_MAX) begin
                    sum_next   = sum_sat;
                    count_next = count_reg + 1'b1;
                end
                if (last_reg) begin
                    quo_next   = (count_reg < CNT_MAX) ? sum_sat : sum_reg;
                    div_next   = (count_reg < CNT_MAX) ? count_reg + 1'b1 : count_reg;
                    rmd_next   = '0;
                    iter_next  = ITER_W'(DIV_STEPS - 1);
                    sum_next   = '0;
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                // One restoring quotient bit a cycle
                rmd_next = sub_ge ? sub_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], sub_ge};
                if (iter_reg == '0) begin
                    rad_next   = {quo_reg[MEAN_W-2:0], sub_ge};
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = ITER_W'(SQRT_STEPS - 1);
                    state_next = ST_ROOT;
                end else begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_ROOT: begin
                // One root bit a cycle from the next two radicand bits
                rem_next  = sub_ge ? sub_diff[REM_W-1:0] : root_shift[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                rad_next  = {rad_reg[MEAN_W-3:0], 2'b00};
                if (iter_reg == '0) begin
                    state_next = ST_DECIDE;
                end else begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            ST_DECIDE: begin
                // Update the session counters and hand the result over when the slot is free
                if (!ended_reg) begin
                    if (sub_ge) begin
                        speech_next  = (speech_reg == CNT10_MAX) ? speech_reg
                                                                 : speech_reg + 1'b1;
                        silence_next = '0;
                    end else if (speech_reg >= min_reg) begin
                        silence_next = silence_inc;
                        if (silence_inc >= limit_reg) begin
                            ended_next = 1'b1;
                        end
                    end
                end
                if (slot_free) begin
                    m_data_next  = {4'b0000, silence_next, speech_next, root_reg};
                    m_user_next  = {ended_next, sub_ge};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    speech_next  = speech_reg;
                    silence_next = silence_reg;
                    ended_next   = ended_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and session counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            count_reg   <= '0;
            speech_reg  <= '0;
            silence_reg <= '0;
            ended_reg   <= 1'b0;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            speech_reg  <= speech_next;
            silence_reg <= silence_next;
            ended_reg   <= ended_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Configuration writes; an index past the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= THR_RESET;
            limit_reg <= LIMIT_RESET;
            min_reg   <= MIN_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_ENERGY_THRESHOLD: thr_reg   <= cfg_wdata[THR_W-1:0];
                CFG_SILENCE_LIMIT:    limit_reg <= cfg_wdata[CNT10_W-1:0];
                CFG_MIN_SPEECH:       min_reg   <= cfg_wdata[CNT10_W-1:0];
                default: ;
            endcase
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            sample_reg <= s_tdata;
            last_reg   <= s_tlast;
        end
        if (state_reg == ST_SQUARE) begin
            sq_reg <= product[SQ_W-1:0];
        end
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        rmd_reg    <= rmd_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

[rtl/evad_checker.sv]
// Port-level checker for the energy voice activity detector, bound to the top level.
module evad_checker import evad_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [M_DATA_W-1:0]  m_tdata,
    input logic [M_USER_W-1:0]  m_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The sequencer is busy the cycle after taking a request
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while the previous one is in work");

    // A speech chunk before the end clears the silence run
    a_speech_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && !m_tuser[1] |-> m_tdata[35:26] == 10'd0)
        else $error("silence run not cleared by speech");

    // The RMS of 16-bit samples never exceeds full scale
    a_energy_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= 16'd32768)
        else $error("energy out of range");

endmodule

bind energy_vad_end_of_speech_unit evad_checker u_evad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

[verif/tb_energy_vad_end_of_speech_unit.sv]
// Self-checking stream testbench for the energy voice activity detector with end-of-speech latch.
module tb_energy_vad_end_of_speech_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import evad_pkg::*;

    localparam int          MAX_CHUNK    = 512;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_ITEMS = 340;

    // One sample request as it travels on the input stream
    typedef struct packed {
        logic signed [S_DATA_W-1:0] pcm;
        logic                       last;
        logic                       fresh;
    } sample_req_t;

    // One chunk verdict as it should leave the block
    typedef struct packed {
        logic [THR_W-1:0]   energy;
        logic               is_speech;
        logic               ended;
        logic [CNT10_W-1:0] speech_seen;
        logic [CNT10_W-1:0] silence_seen;
    } chunk_result_t;

    typedef enum {LOUD, QUIET, NOISE} chunk_kind_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wen   = 1'b0;
    cfg_idx_t              cfg_index = CFG_ENERGY_THRESHOLD;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    // Register mirror
    logic [THR_W-1:0]      thr_cfg   = THR_RESET;
    logic [CNT10_W-1:0]    limit_cfg = LIMIT_RESET;
    logic [CNT10_W-1:0]    min_cfg   = MIN_RESET;

    // Detector state mirror
    logic [SUM_W-1:0]      sq_acc      = '0;
    int unsigned           acc_n       = 0;
    logic [CNT10_W-1:0]    speech_cnt  = '0;
    logic [CNT10_W-1:0]    silence_cnt = '0;
    logic                  end_latched = 1'b0;

    sample_req_t           pend_q[$];
    chunk_result_t         energy_q[$];
    sample_req_t           on_bus;
    logic                  calm       = 1'b0;
    int unsigned           hold_asks  = 0;
    int unsigned           hold_taken = 0;
    int unsigned           send_gap   = 0;
    int unsigned           recv_stall = 0;
    int unsigned           queued     = 0;
    int unsigned           samples_sent  = 0;
    int unsigned           results_seen  = 0;
    int unsigned           ended_results = 0;
    int unsigned           reg_writes    = 0;
    int unsigned           mismatches    = 0;
    int unsigned           cycle_cnt     = 0;

    always #1 aclk = ~aclk;

    energy_vad_end_of_speech_unit #(
        .MAX_CHUNK_SAMPLES(MAX_CHUNK)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Largest r with r*r <= v, found one bit at a time from the top
    function automatic logic [THR_W-1:0] root_floor(logic [63:0] v);
        logic [16:0] r;
        logic [16:0] t;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (17'd1 << b);
            if (64'(t) * 64'(t) <= v) begin
                r = t;
            end
        end
        return r[THR_W-1:0];
    endfunction

    // Fold one accepted sample into the mirror; queue a verdict on a chunk end
    task automatic predict_sample(sample_req_t req);
        logic signed [63:0] sv;
        logic [63:0]        total;
        logic [63:0]        mean;
        logic [THR_W-1:0]   nrg;
        logic               spk;
        chunk_result_t      res;
        if (req.fresh) begin
            sq_acc      = '0;
            acc_n       = 0;
            speech_cnt  = '0;
            silence_cnt = '0;
            end_latched = 1'b0;
        end
        // Drop samples once the chunk is full
        if (acc_n < MAX_CHUNK) begin
            sv     = req.pcm;
            total  = 64'(sq_acc) + 64'(sv * sv);
            sq_acc = (total > 64'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
            acc_n++;
        end
        if (req.last) begin
            mean   = 64'(sq_acc) / 64'(acc_n);
            nrg    = root_floor(mean);
            spk    = (nrg >= thr_cfg);
            sq_acc = '0;
            acc_n  = 0;
            // Counters hold once the end has latched
            if (!end_latched) begin
                if (spk) begin
                    if (speech_cnt != CNT10_MAX) speech_cnt++;
                    silence_cnt = '0;
                end else if (speech_cnt >= min_cfg) begin
                    if (silence_cnt != CNT10_MAX) silence_cnt++;
                    if (silence_cnt >= limit_cfg) end_latched = 1'b1;
                end
            end
            res.energy       = nrg;
            res.is_speech    = spk;
            res.ended        = end_latched;
            res.speech_seen  = speech_cnt;
            res.silence_seen = silence_cnt;
            energy_q.push_back(res);
        end
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch in result %0d: %s got %0d expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    // Sender: advance on acceptance, then offer the next request after its gap
    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_sample(on_bus);
                samples_sent++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (pend_q.size() != 0) begin
                    on_bus = pend_q.pop_front();
                    s_tdata <= on_bus.pcm;
                    s_tlast <= on_bus.last;
                    s_tuser <= on_bus.fresh;
                    offer = 1'b1;
                    send_gap = calm ? 0 : pick_gap();
                end
            end
            s_tvalid <= offer;
        end
    end

    // Receiver: check each accepted verdict, then pick the next ready level
    always @(posedge aclk) begin
        chunk_result_t want;
        logic          take;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (energy_q.size() == 0) begin
                    report_mismatch("unexpected result, tdata", m_tdata, 0);
                end else begin
                    want = energy_q.pop_front();
                    if (want.ended) ended_results++;
                    if (m_tdata[15:0] != want.energy)
                        report_mismatch("energy", m_tdata[15:0], want.energy);
                    if (m_tdata[25:16] != want.speech_seen)
                        report_mismatch("speech_seen", m_tdata[25:16], want.speech_seen);
                    if (m_tdata[35:26] != want.silence_seen)
                        report_mismatch("silence_seen", m_tdata[35:26], want.silence_seen);
                    if (m_tdata[M_DATA_W-1:36] != '0)
                        report_mismatch("tdata padding", m_tdata[M_DATA_W-1:36], 0);
                    if (m_tuser[0] != want.is_speech)
                        report_mismatch("is_speech", m_tuser[0], want.is_speech);
                    if (m_tuser[1] != want.ended)
                        report_mismatch("end_of_speech", m_tuser[1], want.ended);
                end
            end
            // Long hold-off on request, counted here
            if (hold_taken != hold_asks) begin
                hold_taken++;
                recv_stall = HOLD_CYCLES;
            end
            if (recv_stall != 0) begin
                recv_stall--;
                take = 1'b0;
            end else begin
                take = 1'b1;
                recv_stall = calm ? 0 : pick_gap();
            end
            m_tready <= take;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt,
                     energy_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_sample(logic [S_DATA_W-1:0] pcm, logic last, logic fresh);
        pend_q.push_back('{pcm: pcm, last: last, fresh: fresh});
        queued++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ENERGY_THRESHOLD: thr_cfg = val[THR_W-1:0];
            CFG_SILENCE_LIMIT:    limit_cfg = val[CNT10_W-1:0];
            default:              min_cfg = val[CNT10_W-1:0];
        endcase
        reg_writes++;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic set_regs(int unsigned thr, int unsigned lim, int unsigned min_sp);
        write_reg(CFG_ENERGY_THRESHOLD, CFG_W'(thr));
        write_reg(CFG_SILENCE_LIMIT, CFG_W'(lim));
        write_reg(CFG_MIN_SPEECH, CFG_W'(min_sp));
    endtask

    // Wait until all requests are in and all verdicts are out, then let the block settle
    task automatic wait_idle();
        do @(posedge aclk);
        while (samples_sent != queued || energy_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Sample whose chunk lands on the wanted side of the current threshold; a noise sample is random
    function automatic logic [S_DATA_W-1:0] pick_sample(chunk_kind_t kind);
        int unsigned         mag;
        logic [S_DATA_W-1:0] s;
        case (kind)
            LOUD: begin
                if (thr_cfg > 16'd32767) return 16'h8000;
                mag = $urandom_range(32767, thr_cfg);
            end
            QUIET: begin
                if (thr_cfg == '0) return S_DATA_W'($urandom_range(65535));
                mag = $urandom_range(thr_cfg - 1, 0);
            end
            default: return S_DATA_W'($urandom_range(65535));
        endcase
        s = mag[S_DATA_W-1:0];
        return $urandom_range(1) ? -s : s;
    endfunction

    task automatic add_chunk(int unsigned len, chunk_kind_t kind, logic fresh, logic closed);
        for (int i = 0; i < len; i++) begin
            push_sample(pick_sample(kind), closed && (i == len - 1), fresh && (i == 0));
        end
    endtask

    // Speech to arm, silence to end, a short tail after the latch, sometimes cut short
    task automatic add_session();
        int unsigned n_loud;
        int unsigned n_quiet;
        int unsigned n_tail;
        int unsigned len;
        chunk_kind_t kind;
        n_loud  = min_cfg + $urandom_range(2);
        n_quiet = limit_cfg + $urandom_range(2);
        n_tail  = $urandom_range(3);
        for (int i = 0; i < n_loud + n_quiet + n_tail; i++) begin
            if (i < n_loud) begin
                kind = LOUD;
            end else if (i < n_loud + n_quiet) begin
                kind = QUIET;
                if ($urandom_range(9) == 0) kind = LOUD;
            end else begin
                kind = QUIET;
                if ($urandom_range(1) == 1) kind = LOUD;
            end
            if ($urandom_range(99) < 12) kind = NOISE;
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
            add_chunk(len, kind, i == 0, 1'b1);
        end
        if ($urandom_range(9) == 0) add_chunk($urandom_range(5, 1), NOISE, 1'b0, 1'b0);
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned start_mark;
        int unsigned p;
        random_sent = 0;
        p = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, threshold edge, exact roots, restart mid-chunk
        push_sample(16'h8000, 1'b1, 1'b1);
        push_sample(16'h7FFF, 1'b1, 1'b0);
        push_sample(16'h0000, 1'b0, 1'b0);
        push_sample(16'h0000, 1'b0, 1'b0);
        push_sample(16'h0000, 1'b1, 1'b0);
        push_sample(16'h0001, 1'b0, 1'b0);
        push_sample(16'hFFFF, 1'b1, 1'b0);
        push_sample(16'd399, 1'b0, 1'b0);
        push_sample(-16'sd399, 1'b1, 1'b0);
        push_sample(16'd400, 1'b1, 1'b0);
        push_sample(16'd20, 1'b0, 1'b0);
        push_sample(16'd21, 1'b1, 1'b0);
        push_sample(16'd5000, 1'b0, 1'b0);
        push_sample(-16'sd5000, 1'b1, 1'b1);
        push_sample(16'h8000, 1'b0, 1'b0);
        push_sample(16'h7FFF, 1'b0, 1'b0);
        push_sample(16'h0000, 1'b1, 1'b0);
        push_sample(16'h5555, 1'b1, 1'b0);
        push_sample(16'hAAAA, 1'b1, 1'b0);
        wait_idle();

        // Back-pressure: receiver holds off while one-sample chunks keep coming
        hold_asks <= hold_asks + 1;
        add_chunk(1, NOISE, 1'b1, 1'b1);
        repeat (39) add_chunk(1, NOISE, 1'b0, 1'b1);
        wait_idle();

        // Random sessions under rotating register settings
        while (random_sent < RANDOM_ITEMS) begin
            case (p % 5)
                0: set_regs($urandom_range(3000, 50), $urandom_range(6, 1), $urandom_range(4));
                1: set_regs($urandom_range(1000, 200), 0, 0);
                2: set_regs(32768, $urandom_range(3, 1), 0);
                3: set_regs(1, 1, 1);
                default: set_regs($urandom_range(32767, 1000), $urandom_range(6, 2),
                                  $urandom_range(3, 1));
            endcase
            calm <= (p % 5 == 2);
            start_mark = queued;
            while (queued - start_mark < 60) add_session();
            random_sent += queued - start_mark;
            wait_idle();
            p++;
        end

        $display("summary: %0d samples, %0d chunk verdicts checked, %0d register writes",
                 samples_sent, results_seen, reg_writes);
        $display("summary: %0d verdicts after the end latch; random sessions, edge values, stalls",
                 ended_results);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
